// ----- rtl/line_sensor_average_threshold_defines.svh -----
// ----------------------------------------------------------------------------
// Line sensor assertion macros
// Shared property wrappers for the checker, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_AVERAGE_THRESHOLD_DEFINES_SVH
`define LINE_SENSOR_AVERAGE_THRESHOLD_DEFINES_SVH

// same-cycle implication
`define LSAT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lsat: property failed");

// next-cycle implication
`define LSAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lsat: property failed");

`endif

// ----- rtl/lsat_pkg.sv -----
// ----------------------------------------------------------------------------
// Line sensor package
// Sizes, command codes and the request/response types of the averaging unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lsat_pkg;

  localparam int unsigned SENSORS  = 16;
  localparam int unsigned WINDOW   = 5;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned CMD_W    = 8;
  localparam int unsigned BYTE_W   = 8;

  localparam int unsigned SENS_IW  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int unsigned BIDX_W   = $clog2(SENSORS + 1);
  localparam int unsigned DEPTH    = SENSORS * WINDOW;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W    = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W    =
    $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + WINDOW / 2 + 1);

  localparam int unsigned RECIP_SH = SUM_W + 2;
  localparam int unsigned RECIP_W  = RECIP_SH + 1;
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / WINDOW);

  localparam int unsigned VALUE_SHIFT = 2;
  localparam int unsigned PACK_W      = 2 * BYTE_W;

  localparam logic [SAMPLE_W-1:0] THR_RESET = SAMPLE_W'(90);

  localparam logic [CMD_W-1:0]  CMD_SETCOLOR  = 8'd255;
  localparam logic [CMD_W-1:0]  CMD_PACKED    = 8'd254;
  localparam logic [CMD_W-1:0]  CMD_PING      = 8'd253;
  localparam logic [CMD_W-1:0]  CMD_VALUES    = 8'd252;
  localparam logic [CMD_W-1:0]  CMD_FLAGS     = 8'd251;
  localparam logic [BYTE_W-1:0] MARK_BYTE     = 8'd255;
  localparam logic [1:0]        SWALLOW_COUNT = 2'd3;

  typedef struct packed {
    logic                start;
    logic [SENS_IW-1:0]  pos;
    logic [SAMPLE_W-1:0] sample;
  } avg_req_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] avg;
  } avg_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/lsat_avg_unit.sv -----
// ----------------------------------------------------------------------------
// Line sensor averaging unit
// Per-sensor circular windows in one memory; one adder sums the window a
// beat per cycle, then a reciprocal multiply and a correction give the mean.
// ----------------------------------------------------------------------------
`default_nettype none

module lsat_avg_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lsat_pkg::avg_req_t req_i,
  output lsat_pkg::avg_rsp_t     rsp_o
);
  import lsat_pkg::*;

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_ACC  = 4'b0010,
    U_MUL  = 4'b0100,
    U_FIX  = 4'b1000
  } ustate_e;

  ustate_e state_q, state_d;

  logic [SAMPLE_W-1:0] win_mem [DEPTH];
  logic [DEPTH-1:0]    vld_q;
  logic [SLOT_W-1:0]   head_q [SENSORS];

  logic [SENS_IW-1:0]  pos_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SUM_W-1:0]    sum_q;
  logic [PROD_W-1:0]   prod_q;
  logic [SAMPLE_W-1:0] rd_data_q;
  logic                rd_ok_q;

  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_en;
  logic [SLOT_W-1:0]   head_cur;
  logic [SLOT_W-1:0]   head_next;
  logic [SUM_W-1:0]    q0;
  logic [SUM_W-1:0]    rem;
  logic [SUM_W-1:0]    q_fix;

  assign head_cur  = head_q[req_i.pos];
  assign head_next = (head_cur == SLOT_W'(WINDOW - 1)) ? '0 : head_cur + SLOT_W'(1);
  assign wr_addr   = ADDR_W'(req_i.pos * WINDOW) + ADDR_W'(head_cur);
  assign rd_addr   = ADDR_W'(pos_q * WINDOW) + ADDR_W'(cnt_q);
  assign rd_en     = (state_q == U_ACC) && (cnt_q < CNT_W'(WINDOW));

  assign q0    = SUM_W'(prod_q >> RECIP_SH);
  assign rem   = sum_q - SUM_W'(q0 * WINDOW);
  assign q_fix = (rem >= SUM_W'(WINDOW)) ? q0 + SUM_W'(1) : q0;

  assign rsp_o.done = (state_q == U_FIX);
  assign rsp_o.avg  = q_fix[SAMPLE_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      U_IDLE: if (req_i.start) state_d = U_ACC;
      U_ACC:  if (cnt_q == CNT_W'(WINDOW)) state_d = U_MUL;
      U_MUL:  state_d = U_FIX;
      U_FIX:  state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      vld_q   <= '0;
      rd_ok_q <= 1'b0;
      cnt_q   <= '0;
      for (int i = 0; i < SENSORS; i++) begin
        head_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      rd_ok_q <= rd_en && vld_q[rd_addr];
      if (req_i.start) begin
        vld_q[wr_addr]     <= 1'b1;
        head_q[req_i.pos]  <= head_next;
        cnt_q              <= '0;
      end else if (state_q == U_ACC) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      pos_q <= req_i.pos;
      sum_q <= SUM_W'(WINDOW / 2);
    end else if (state_q == U_ACC && cnt_q != '0) begin
      sum_q <= sum_q + (rd_ok_q ? SUM_W'(rd_data_q) : '0);
    end
    if (state_q == U_MUL) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      win_mem[wr_addr] <= req_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= win_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/line_sensor_average_threshold.sv -----
// ----------------------------------------------------------------------------
// Line sensor average and threshold
// Sixteen-channel boxcar average with line flags and a byte command reply.
// ----------------------------------------------------------------------------
//  port group   direction  handshake               payload
//  cfg          in         cfg_we_i                cfg_wdata_i (threshold)
//  in           in         in_valid_i / in_ready_o func_i channel_i sample_i command_i
//  out          out        out_valid_o / out_ready_i tx_byte_o last_byte_o
//
//  A sample beat holds the input while the window is summed one entry per
//  cycle through one adder, then multiplied and corrected. A command beat
//  loads its reply bytes into the output register one after another;
//  the last byte waits in the output register while the next beat enters.
//  A stalled output holds the sequencer. Reset clears the window valid bits,
//  so every window reads as zero at once; the threshold resets to 90.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_average_threshold (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lsat_pkg::SAMPLE_W-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          func_i,
  input  wire logic [lsat_pkg::CHAN_W-1:0]   channel_i,
  input  wire logic [lsat_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic [lsat_pkg::CMD_W-1:0]    command_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [lsat_pkg::BYTE_W-1:0]        tx_byte_o,
  output logic                               last_byte_o
);
  import lsat_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_AVG  = 3'b010,
    S_TX   = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    RPL_PING,
    RPL_PACKED,
    RPL_VALUES,
    RPL_FLAGS
  } reply_e;

  localparam logic [CHAN_W:0] SENS_C = (CHAN_W + 1)'(SENSORS);
  localparam logic [CHAN_W:0] HALF_C = (CHAN_W + 1)'(SENSORS / 2);
  localparam logic [CHAN_W:0] ONE_C  = (CHAN_W + 1)'(1);

  state_e              state_q, state_d;
  reply_e              kind_q;
  logic [BIDX_W-1:0]   idx_q;
  logic [1:0]          swallow_q;
  logic [SAMPLE_W-1:0] thr_q;
  logic [SAMPLE_W-1:0] avg_q [SENSORS];
  logic [SENSORS-1:0]  seen_q;
  logic [SENS_IW-1:0]  pos_q;
  logic                out_valid_q;
  logic [BYTE_W-1:0]   tx_byte_q;
  logic                last_q;

  logic                in_fire;
  logic [CHAN_W:0]     chan_x;
  logic [CHAN_W:0]     pos_x;
  logic                chan_ok;
  logic [SENS_IW-1:0]  pos_in;
  logic                out_load;
  logic [BYTE_W-1:0]   byte_sel;
  logic                last_sel;
  logic [BIDX_W-1:0]   idx_m1;
  logic [SENS_IW-1:0]  sidx;
  logic [PACK_W-1:0]   flag_vec;

  avg_req_t avg_req;
  avg_rsp_t avg_rsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign chan_x  = {1'b0, channel_i};
  assign chan_ok = chan_x < SENS_C;
  assign pos_x   = (chan_x < HALF_C) ? HALF_C - ONE_C - chan_x
                                     : SENS_C - ONE_C - (chan_x - HALF_C);
  assign pos_in  = pos_x[SENS_IW-1:0];

  assign avg_req.start  = in_fire && !func_i && chan_ok;
  assign avg_req.pos    = pos_in;
  assign avg_req.sample = sample_i;

  lsat_avg_unit u_avg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (avg_req),
    .rsp_o  (avg_rsp)
  );

  assign out_load = (state_q == S_TX) && (!out_valid_q || out_ready_i);
  assign idx_m1   = idx_q - BIDX_W'(1);
  assign sidx     = idx_m1[SENS_IW-1:0];
  assign flag_vec = PACK_W'(seen_q);

  always_comb begin
    byte_sel = MARK_BYTE;
    last_sel = 1'b0;
    case (kind_q)
      RPL_PING: begin
        last_sel = 1'b1;
      end
      RPL_PACKED: begin
        if (idx_q == BIDX_W'(1)) begin
          byte_sel = flag_vec[BYTE_W-1:0];
        end else if (idx_q != '0) begin
          byte_sel = flag_vec[PACK_W-1:BYTE_W];
        end
        last_sel = (idx_q == BIDX_W'(2));
      end
      RPL_VALUES: begin
        if (idx_q != '0) begin
          byte_sel = BYTE_W'(avg_q[sidx] >> VALUE_SHIFT);
        end
        last_sel = (idx_q == BIDX_W'(SENSORS));
      end
      RPL_FLAGS: begin
        if (idx_q != '0) begin
          byte_sel = BYTE_W'(seen_q[sidx]);
        end
        last_sel = (idx_q == BIDX_W'(SENSORS));
      end
      default: begin
        last_sel = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!func_i) begin
            if (chan_ok) state_d = S_AVG;
          end else if (swallow_q == '0) begin
            case (command_i)
              CMD_PACKED, CMD_PING, CMD_VALUES, CMD_FLAGS: state_d = S_TX;
              default: state_d = S_IDLE;
            endcase
          end
        end
      end
      S_AVG:   if (avg_rsp.done) state_d = S_IDLE;
      S_TX:    if (out_load && last_sel) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= RPL_PING;
      idx_q       <= '0;
      swallow_q   <= '0;
      thr_q       <= THR_RESET;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
        avg_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (state_q == S_IDLE && in_fire && func_i) begin
        if (swallow_q != '0) begin
          swallow_q <= swallow_q - 2'd1;
        end else begin
          idx_q <= '0;
          case (command_i)
            CMD_SETCOLOR: swallow_q <= SWALLOW_COUNT;
            CMD_PACKED:   kind_q    <= RPL_PACKED;
            CMD_PING:     kind_q    <= RPL_PING;
            CMD_VALUES:   kind_q    <= RPL_VALUES;
            CMD_FLAGS:    kind_q    <= RPL_FLAGS;
            default:      kind_q    <= kind_q;
          endcase
        end
      end
      if (state_q == S_AVG && avg_rsp.done) begin
        avg_q[pos_q]  <= avg_rsp.avg;
        seen_q[pos_q] <= avg_rsp.avg > thr_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_q + BIDX_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (avg_req.start) pos_q <= pos_in;
    if (out_load) begin
      tx_byte_q <= byte_sel;
      last_q    <= last_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign last_byte_o = last_q;

endmodule

`default_nettype wire

// ----- rtl/lsat_checker.sv -----
// ----------------------------------------------------------------------------
// Line sensor port checker
// Watches the top level ports for reply sequencing and busy periods.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_sensor_average_threshold_defines.svh"

module lsat_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        func_i,
  input wire logic [lsat_pkg::CHAN_W-1:0] channel_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [lsat_pkg::BYTE_W-1:0] tx_byte_o,
  input wire logic                        last_byte_o
);
  import lsat_pkg::*;

  localparam logic [CHAN_W:0] SENS_C = (CHAN_W + 1)'(SENSORS);

  logic              chan_ok;
  logic              out_stall;
  logic              sample_fire;
  logic [BYTE_W:0]   out_word;

  assign chan_ok     = {1'b0, channel_i} < SENS_C;
  assign out_stall   = out_valid_o && !out_ready_i;
  assign sample_fire = in_valid_i && in_ready_o && !func_i && chan_ok;
  assign out_word    = {tx_byte_o, last_byte_o};

  // hold a stalled beat
  `LSAT_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_word))
  // no new beat while a reply is still in flight
  `LSAT_ASSERT_SAME(a_busy_mid_reply, out_valid_o && !last_byte_o, !in_ready_o)
  // advance a reply without gaps
  `LSAT_ASSERT_NEXT(a_reply_gapless, out_valid_o && out_ready_i && !last_byte_o, out_valid_o)
  // a mapped sample keeps the block busy
  `LSAT_ASSERT_NEXT(a_sample_busy, sample_fire, !in_ready_o)

endmodule

bind line_sensor_average_threshold lsat_checker u_checker (.*);

`default_nettype wire

// ----- tb/line_sensor_average_threshold_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line sensor average and threshold checker
// Watches the configuration, input and reply channels. It keeps its own copy
// of the sensor windows, averages, flags and swallow count, predicts the reply
// bytes of every accepted command beat, and compares each reply beat in order.
// ----------------------------------------------------------------------------
module line_sensor_average_threshold_checker
  import lsat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SAMPLE_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                func_i,
  input  logic [CHAN_W-1:0]   channel_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [CMD_W-1:0]    command_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [BYTE_W-1:0]   tx_byte_i,
  input  logic                last_byte_i,
  output int                  mismatches_o,
  output int                  pending_o,
  output int                  bytes_seen_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic              last_byte;
  } reply_byte_t;

  reply_byte_t         reply_q[$];
  logic [SAMPLE_W-1:0] window_mem [SENSORS][WINDOW];
  logic [SAMPLE_W-1:0] mean_mem [SENSORS];
  logic                sensor_flag [SENSORS];
  logic [1:0]          skip_left;
  logic [SAMPLE_W-1:0] threshold;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    bytes_seen_o = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns  reply mismatch, %s: got %0d, expected %0d", $time, what, got, want);
    mismatches_o++;
  endtask

  task automatic push_reply(input logic [BYTE_W-1:0] b, input logic l);
    reply_byte_t r;
    r.tx_byte   = b;
    r.last_byte = l;
    reply_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    int                pos;
    int                total;
    logic [BYTE_W-1:0] low_flags;
    logic [BYTE_W-1:0] high_flags;
    reply_byte_t       want;
    if (!rst_ni) begin
      for (int s = 0; s < SENSORS; s++) begin
        for (int k = 0; k < WINDOW; k++) window_mem[s][k] = '0;
        mean_mem[s]    = '0;
        sensor_flag[s] = 1'b0;
      end
      skip_left = '0;
      threshold = THR_RESET;
      reply_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        bytes_seen_o++;
        if (reply_q.size() == 0) begin
          report_mismatch("beat with nothing outstanding", tx_byte_i, -1);
        end else begin
          want = reply_q.pop_front();
          if (tx_byte_i !== want.tx_byte) report_mismatch("tx_byte", tx_byte_i, want.tx_byte);
          if (last_byte_i !== want.last_byte)
            report_mismatch("last_byte", last_byte_i, want.last_byte);
        end
      end
      if (cfg_we_i) threshold = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (!func_i) begin
          if (channel_i < SENSORS) begin
            pos = (channel_i < SENSORS / 2) ? SENSORS / 2 - 1 - channel_i
                                            : SENSORS - 1 - (channel_i - SENSORS / 2);
            for (int k = WINDOW - 1; k > 0; k--) window_mem[pos][k] = window_mem[pos][k-1];
            window_mem[pos][0] = sample_i;
            total = 0;
            for (int k = 0; k < WINDOW; k++) total += window_mem[pos][k];
            total = (total + WINDOW / 2) / WINDOW;
            mean_mem[pos]    = SAMPLE_W'(total);
            sensor_flag[pos] = (total > threshold);
          end
        end else if (skip_left != 0) begin
          skip_left--;
        end else begin
          case (command_i)
            CMD_SETCOLOR: begin
              skip_left = SWALLOW_COUNT;
            end
            CMD_PACKED: begin
              low_flags  = '0;
              high_flags = '0;
              for (int i = 0; i < 8; i++) begin
                if (i < SENSORS && sensor_flag[i]) low_flags[i] = 1'b1;
                if (i + 8 < SENSORS && sensor_flag[i+8]) high_flags[i] = 1'b1;
              end
              push_reply(MARK_BYTE, 1'b0);
              push_reply(low_flags, 1'b0);
              push_reply(high_flags, 1'b1);
            end
            CMD_PING: begin
              push_reply(MARK_BYTE, 1'b1);
            end
            CMD_VALUES: begin
              push_reply(MARK_BYTE, 1'b0);
              for (int i = 0; i < SENSORS; i++)
                push_reply(BYTE_W'(mean_mem[i] >> VALUE_SHIFT), i == SENSORS - 1);
            end
            CMD_FLAGS: begin
              push_reply(MARK_BYTE, 1'b0);
              for (int i = 0; i < SENSORS; i++)
                push_reply(BYTE_W'(sensor_flag[i]), i == SENSORS - 1);
            end
            default: begin
            end
          endcase
        end
      end
    end
    pending_o = reply_q.size();
  end

endmodule

// ----- tb/line_sensor_average_threshold_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line sensor average and threshold testbench
// Drives directed sample and command beats, then random traffic in three
// phases with different thresholds and idling on both channels. A checker
// beside the block predicts and compares every reply byte.
// ----------------------------------------------------------------------------
module line_sensor_average_threshold_tb;
  import lsat_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int DRAIN_TAIL  = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [SAMPLE_W-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                func_i      = 1'b0;
  logic [CHAN_W-1:0]   channel_i   = '0;
  logic [SAMPLE_W-1:0] sample_i    = '0;
  logic [CMD_W-1:0]    command_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [BYTE_W-1:0]   tx_byte_o;
  logic                last_byte_o;

  int                  send_idle_pct = 23;
  int                  recv_idle_pct = 56;
  int                  cycle_count   = 0;
  int                  beats_sent    = 0;
  int                  mismatches;
  int                  pending_bytes;
  int                  bytes_checked;
  logic [SAMPLE_W-1:0] threshold_now = THR_RESET;
  logic [SAMPLE_W-1:0] random_threshold;
  logic [CMD_W-1:0]    reply_cmds [4];

  line_sensor_average_threshold uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .channel_i   (channel_i),
    .sample_i    (sample_i),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

  line_sensor_average_threshold_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .func_i       (func_i),
    .channel_i    (channel_i),
    .sample_i     (sample_i),
    .command_i    (command_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tx_byte_i    (tx_byte_o),
    .last_byte_i  (last_byte_o),
    .mismatches_o (mismatches),
    .pending_o    (pending_bytes),
    .bytes_seen_o (bytes_checked)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_beat(input logic f, input logic [CHAN_W-1:0] ch,
                           input logic [SAMPLE_W-1:0] smp, input logic [CMD_W-1:0] cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    channel_i  <= ch;
    sample_i   <= smp;
    command_i  <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] val);
    send_beat(1'b0, ch, val, CMD_W'($urandom_range(255)));
  endtask

  task automatic send_command(input logic [CMD_W-1:0] cmd);
    send_beat(1'b1, CHAN_W'($urandom_range(15)), SAMPLE_W'($urandom_range(1023)), cmd);
  endtask

  // hold the sender until every reply beat is in, then let the averager settle
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [SAMPLE_W-1:0] val);
    drain_replies();
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= val;
    threshold_now  = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int s_pct, input int r_pct,
                           input logic [SAMPLE_W-1:0] thr);
    int pick;
    int lo_v;
    int hi_v;
    logic [SAMPLE_W-1:0] val;
    write_threshold(thr);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    send_command(CMD_FLAGS);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_replies();
      pick = $urandom_range(99);
      if (pick < 55) begin
        if ($urandom_range(1)) begin
          val = SAMPLE_W'($urandom_range(1023));
        end else begin
          lo_v = (threshold_now > 40) ? threshold_now - 40 : 0;
          hi_v = (threshold_now < 983) ? threshold_now + 40 : 1023;
          val  = SAMPLE_W'($urandom_range(hi_v, lo_v));
        end
        send_sample(CHAN_W'($urandom_range(15)), val);
      end else if (pick < 80) begin
        send_command(reply_cmds[$urandom_range(3)]);
      end else if (pick < 90) begin
        send_command(CMD_SETCOLOR);
        repeat (SWALLOW_COUNT) begin
          if ($urandom_range(3) == 0)
            send_sample(CHAN_W'($urandom_range(15)), SAMPLE_W'($urandom_range(1023)));
          send_command(CMD_W'($urandom_range(255)));
        end
      end else begin
        send_command(CMD_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    reply_cmds[0] = CMD_PACKED;
    reply_cmds[1] = CMD_PING;
    reply_cmds[2] = CMD_VALUES;
    reply_cmds[3] = CMD_FLAGS;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(CMD_PING);
    send_command(CMD_VALUES);
    send_command(CMD_PACKED);
    send_command(CMD_FLAGS);
    send_sample(4'd0, 10'd1023);
    send_sample(4'd7, 10'd1023);
    send_sample(4'd8, 10'd1023);
    send_sample(4'd15, 10'd1023);
    send_sample(4'd3, 10'd3);
    send_sample(4'd3, 10'd2);
    send_command(CMD_PACKED);
    send_command(CMD_FLAGS);
    send_command(CMD_VALUES);
    send_command(CMD_SETCOLOR);
    send_command(CMD_SETCOLOR);
    send_sample(4'd12, 10'd700);
    send_command(CMD_PING);
    send_command(CMD_FLAGS);
    send_command(CMD_PING);
    send_command(8'd0);
    send_command(8'd250);
    send_sample(4'd0, 10'd0);
    send_command(CMD_VALUES);

    run_phase(38, 23, 56, 10'd0);
    run_phase(30, 56, 23, 10'd1023);
    random_threshold = SAMPLE_W'($urandom_range(1022, 1));
    run_phase(38, 0, 0, random_threshold);
    drain_replies();

    $display("summary: %0d input beats accepted, %0d reply beats checked",
             beats_sent, bytes_checked);
    $display("summary: thresholds 90, 0, 1023 and %0d; all commands, swallowed bytes, %s",
             random_threshold, "three idling profiles");
    if (mismatches == 0 && pending_bytes == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
